/* sv/wmbf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wmbf_pkg;

  localparam int IDX_W   = 11;
  localparam int SMP_W   = 16;
  localparam int LEV_W   = 2;
  localparam int QUO_W   = SMP_W + 1;  // quotient magnitude, up to 2^15
  localparam int SUM_W   = 21;         // window sum, signed
  localparam int RECIP_W = 22;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int RAD_W   = 4;
  localparam int CNT_W   = 5;
  localparam int SH_W    = 5;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [IDX_W-1:0]        sample_index;
    logic signed [SMP_W-1:0] sample_value;
    logic [LEV_W-1:0]        mip_level;
  } in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered_value;
    logic [IDX_W-1:0]        result_index;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_TAIL,
    ST_ABS,
    ST_MUL,
    ST_FIN
  } st_e;

  // Window radius 2^m; level 0 is the bare sample.
  function automatic logic [RAD_W-1:0] lev_radius(input logic [LEV_W-1:0] lev);
    logic [RAD_W-1:0] r;
    case (lev)
      2'd0:    r = 4'd0;
      2'd1:    r = 4'd2;
      2'd2:    r = 4'd4;
      2'd3:    r = 4'd8;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // Window length minus one.
  function automatic logic [CNT_W-1:0] lev_span_m1(input logic [LEV_W-1:0] lev);
    logic [CNT_W-1:0] s;
    case (lev)
      2'd0:    s = 5'd0;
      2'd1:    s = 5'd4;
      2'd2:    s = 5'd8;
      2'd3:    s = 5'd16;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // ceil(2^S / span) with S = SUM_W + ceil(log2(span)): exact floor divide
  // for any magnitude below 2^SUM_W.
  function automatic logic [RECIP_W-1:0] lev_recip(input logic [LEV_W-1:0] lev);
    logic [RECIP_W-1:0] m;
    case (lev)
      2'd0:    m = 22'd2097152;  // span 1
      2'd1:    m = 22'd3355444;  // span 5
      2'd2:    m = 22'd3728271;  // span 9
      2'd3:    m = 22'd3947581;  // span 17
      default: m = 22'd2097152;
    endcase
    return m;
  endfunction

  function automatic logic [SH_W-1:0] lev_shift(input logic [LEV_W-1:0] lev);
    logic [SH_W-1:0] s;
    case (lev)
      2'd0:    s = 5'd21;
      2'd1:    s = 5'd24;
      2'd2:    s = 5'd25;
      2'd3:    s = 5'd26;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/wavetable_mip_box_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Single-frame wavetable store with box-filtered mip reads. A write item
// (req_type 0) stores sample_value at sample_index and gives no result; a
// read item (req_type 1) gives one result: the stored sample at mip level 0,
// or at level m the circular average of the 2*2^m+1 samples centered on the
// index, wrapping at the frame ends, truncated toward zero. Indexes are
// taken modulo FRAME_LEN and levels saturate at MIP_LEVELS-1. The frame sits
// in one single-port synchronous RAM read one sample a cycle, so a read item
// reads span samples in turn, span being the window length
// (2^(m+1)+1 at levels 1 to 3, 1 at level 0). After reset the RAM is swept
// to zero, one entry a cycle, from address 0 to FRAME_LEN-1; input stall
// stays high during the sweep. A finished result waits in an output
// register, and the next item is accepted while it waits.

module wavetable_mip_box_filter_top #(
  parameter int FRAME_LEN  = 2048,
  parameter int MIP_LEVELS = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire wmbf_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output wmbf_pkg::out_t      out_data_o
);

  import wmbf_pkg::*;

  localparam int AW       = $clog2(FRAME_LEN);
  localparam int PW       = AW + 1;
  localparam int MW       = 18;  // holds FRAME_LEN << 4 across the range
  localparam int ModSteps = 5;   // 2047 / 64 < 2^5
  localparam logic [AW-1:0] LastAddr = AW'(FRAME_LEN - 1);

  // Frame RAM, single port, registered read.
  logic [SMP_W-1:0] frame_mem [FRAME_LEN];
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [SMP_W-1:0] ram_wdata;
  logic [SMP_W-1:0] ram_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      frame_mem[ram_addr] <= ram_wdata;
    end
    ram_rdata_q <= frame_mem[ram_addr];
  end

  st_e              st_q, st_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             rd_vld_q, rd_vld_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;
  logic             wr_q, wr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SMP_W-1:0] val_q, val_d;
  logic [LEV_W-1:0] lev_q, lev_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] acc_q, acc_d;
  logic [SUM_W-1:0] mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // Index modulo FRAME_LEN by restoring subtraction of FRAME_LEN << k.
  logic [MW-1:0]    idx_rm;
  logic [IDX_W-1:0] idx_red;
  logic [LEV_W-1:0] lev_sat;

  always_comb begin
    idx_rm = MW'(in_data_i.sample_index);
    for (int k = ModSteps - 1; k >= 0; k--) begin
      if (idx_rm >= (MW'(FRAME_LEN) << k)) begin
        idx_rm = idx_rm - (MW'(FRAME_LEN) << k);
      end
    end
  end

  assign idx_red = IDX_W'(idx_rm);
  assign lev_sat = (int'(in_data_i.mip_level) >= MIP_LEVELS) ?
                   LEV_W'(MIP_LEVELS - 1) : in_data_i.mip_level;

  // First window position, idx - radius wrapped into the frame.
  logic [PW-1:0]    idx_ext;
  logic [PW-1:0]    rad_ext;
  logic [AW-1:0]    start_pos;

  assign idx_ext   = PW'(idx_q);
  assign rad_ext   = PW'(lev_radius(lev_q));
  assign start_pos = (idx_ext >= rad_ext) ? AW'(idx_ext - rad_ext) :
                     AW'(idx_ext + PW'(FRAME_LEN) - rad_ext);

  // Quotient and its sign restore.
  logic [QUO_W-1:0] quo;
  logic [SMP_W-1:0] res;

  assign quo = QUO_W'(prod_q >> lev_shift(lev_q));
  assign res = neg_q ? SMP_W'((~quo) + QUO_W'(1)) : SMP_W'(quo);

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    wr_d        = wr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    lev_d       = lev_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    ram_we      = 1'b0;
    ram_addr    = pos_q;
    ram_wdata   = val_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          wr_d  = in_data_i.req_type;
          idx_d = idx_red;
          val_d = in_data_i.sample_value;
          lev_d = lev_sat;
          st_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (wr_q == REQ_WRITE) begin
          ram_we    = 1'b1;
          ram_addr  = AW'(idx_q);
          ram_wdata = val_q;
          st_d      = ST_IDLE;
        end else begin
          pos_d = start_pos;
          cnt_d = '0;
          acc_d = '0;
          st_d  = ST_READ;
        end
      end
      ST_READ: begin
        ram_addr = pos_q;
        rd_vld_d = 1'b1;
        pos_d    = (pos_q == LastAddr) ? '0 : pos_q + AW'(1);
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == lev_span_m1(lev_q)) begin
          st_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        // last sample lands in the accumulator this cycle
        st_d = ST_ABS;
      end
      ST_ABS: begin
        neg_d = acc_q[SUM_W-1];
        mag_d = acc_q[SUM_W-1] ? (~acc_q) + SUM_W'(1) : acc_q;
        st_d  = ST_MUL;
      end
      ST_MUL: begin
        prod_d = PROD_W'(mag_q) * PROD_W'(lev_recip(lev_q));
        st_d   = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.filtered_value = res;
          out_d.result_index   = idx_q;
          st_d                 = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (rd_vld_q) begin
      acc_d = acc_q + {{(SUM_W - SMP_W){ram_rdata_q[SMP_W-1]}}, ram_rdata_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    wr_q   <= wr_d;
    idx_q  <= idx_d;
    val_q  <= val_d;
    lev_q  <= lev_d;
    pos_q  <= pos_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
  end

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
